FILE: rtl/core/evf_pkg.sv
// Shared types and constants for the event queue with selective take.
package evf_pkg;

  localparam int unsigned QueueDepthDefault = 256;
  localparam int unsigned CountW            = 12;
  localparam int unsigned OpW               = 3;
  localparam int unsigned TypeW             = 7;
  localparam int unsigned WindowW           = 32;
  localparam int unsigned PayloadW          = 64;
  localparam int unsigned SerialW           = 32;

  localparam logic [OpW-1:0] OpPush  = 3'd0;
  localparam logic [OpW-1:0] OpPop   = 3'd1;
  localparam logic [OpW-1:0] OpPeek  = 3'd2;
  localparam logic [OpW-1:0] OpTake  = 3'd3;
  localparam logic [OpW-1:0] OpCount = 3'd4;
  localparam logic [OpW-1:0] OpSend  = 3'd5;
  localparam logic [OpW-1:0] OpFlush = 3'd6;

  typedef struct packed {
    logic [OpW-1:0]      operation;
    logic [TypeW-1:0]    kind;
    logic [WindowW-1:0]  window;
    logic [PayloadW-1:0] payload;
  } in_item_t;

  typedef struct packed {
    logic                success;
    logic [TypeW-1:0]    out_type;
    logic [WindowW-1:0]  out_window;
    logic [PayloadW-1:0] out_payload;
    logic [SerialW-1:0]  out_serial;
    logic [CountW-1:0]   queued_count;
  } out_item_t;

  typedef struct packed {
    logic [TypeW-1:0]    kind;
    logic [WindowW-1:0]  window;
    logic [PayloadW-1:0] payload;
    logic [SerialW-1:0]  serial;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

endpackage

FILE: rtl/core/evf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module evf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

FILE: rtl/core/event_fifo_with_selective_take.sv
// Event queue with push, pop, peek, selective take, count, send and flush.
// Push, send, count, flush, or pop/peek/take on an empty queue: result valid in the cycle after accept.
// Pop and peek: one registered RAM read, then the registered result. Take: entries scanned
//   from the oldest up to the match or to the newest, then each older entry moved up one slot to close the gap.
// Next word accepted in the cycle after the result is taken, once idle; words are never overlapped.
// Reset empties the queue and clears the serial counter and own window; RAM is not cleared.
module event_fifo_with_selective_take #(
  parameter int unsigned QUEUE_DEPTH = evf_pkg::QueueDepthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  evf_pkg::in_item_t   in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output evf_pkg::out_item_t  out_item_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [evf_pkg::WindowW-1:0] cfg_data_i
);

  localparam int unsigned IdxW = $clog2(QUEUE_DEPTH);

  typedef enum logic [3:0] {
    StIdle  = 4'b0001,
    StPeek  = 4'b0010,
    StScan  = 4'b0100,
    StShift = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic [IdxW-1:0] head_q, head_d, tail_q, tail_d, scan_q, scan_d, to_q, to_d;
  logic [evf_pkg::CountW-1:0] cnt_q, cnt_d;
  logic [evf_pkg::SerialW-1:0] serial_q, serial_d;
  logic [evf_pkg::WindowW-1:0] own_window_q;
  logic [evf_pkg::OpW-1:0] op_q, op_d;
  logic [evf_pkg::TypeW-1:0] type_q, type_d;
  logic [evf_pkg::WindowW-1:0] win_q, win_d;
  logic out_valid_q, out_valid_d;
  evf_pkg::out_item_t out_q, out_d, res;
  logic res_valid;

  logic we;
  logic [IdxW-1:0] waddr, raddr;
  evf_pkg::entry_t wdata, rdata;
  logic acc;
  logic [IdxW-1:0] from_idx;

  function automatic logic [IdxW-1:0] wrap_next(input logic [IdxW-1:0] i);
    return (i == IdxW'(QUEUE_DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [IdxW-1:0] wrap_prev(input logic [IdxW-1:0] i);
    return (i == '0) ? IdxW'(QUEUE_DEPTH - 1) : i - 1'b1;
  endfunction

  evf_ram #(
    .Width (evf_pkg::EntryW),
    .Depth (QUEUE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign in_ready_o  = (state_q == StIdle) && !out_valid_q;
  assign acc         = in_valid_i && in_ready_o;
  assign cfg_ready_o = (state_q == StIdle) && !out_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
  assign from_idx    = wrap_prev(to_q);

  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    tail_d    = tail_q;
    scan_d    = scan_q;
    to_d      = to_q;
    cnt_d     = cnt_q;
    serial_d  = serial_q;
    op_d      = op_q;
    type_d    = type_q;
    win_d     = win_q;
    res_valid = 1'b0;
    res       = '0;
    raddr     = tail_q;
    we        = 1'b0;
    waddr     = head_q;
    wdata.kind    = in_item_i.kind;
    wdata.window  = in_item_i.window;
    wdata.payload = in_item_i.payload;
    wdata.serial  = serial_q + 1'b1;

    unique case (state_q)
      StIdle: begin
        if (acc) begin
          op_d      = in_item_i.operation;
          type_d    = in_item_i.kind;
          win_d     = in_item_i.window;
          res_valid = 1'b1;
          unique case (in_item_i.operation)
            evf_pkg::OpPush, evf_pkg::OpSend: begin
              if ((in_item_i.operation != evf_pkg::OpSend ||
                   in_item_i.window == own_window_q) &&
                  cnt_q != evf_pkg::CountW'(QUEUE_DEPTH - 1)) begin
                we             = 1'b1;
                serial_d       = serial_q + 1'b1;
                head_d         = wrap_next(head_q);
                cnt_d          = cnt_q + 1'b1;
                res.success    = 1'b1;
                res.out_serial = serial_q + 1'b1;
              end
            end
            evf_pkg::OpPop, evf_pkg::OpPeek: begin
              if (cnt_q != '0) begin
                res_valid = 1'b0;
                state_d   = StPeek;
              end
            end
            evf_pkg::OpTake: begin
              if (cnt_q != '0) begin
                res_valid = 1'b0;
                scan_d    = tail_q;
                state_d   = StScan;
              end
            end
            evf_pkg::OpFlush: begin
              tail_d = head_q;
              cnt_d  = '0;
            end
            default: begin
            end
          endcase
        end
      end
      StPeek: begin
        res_valid       = 1'b1;
        res.success     = 1'b1;
        res.out_type    = rdata.kind;
        res.out_window  = rdata.window;
        res.out_payload = rdata.payload;
        res.out_serial  = rdata.serial;
        if (op_q == evf_pkg::OpPop) begin
          tail_d = wrap_next(tail_q);
          cnt_d  = cnt_q - 1'b1;
        end
        state_d = StIdle;
      end
      StScan: begin
        if (rdata.kind == type_q && rdata.window == win_q) begin
          res_valid       = 1'b1;
          res.success     = 1'b1;
          res.out_type    = rdata.kind;
          res.out_window  = rdata.window;
          res.out_payload = rdata.payload;
          res.out_serial  = rdata.serial;
          cnt_d           = cnt_q - 1'b1;
          if (scan_q == tail_q) begin
            tail_d  = wrap_next(tail_q);
            state_d = StIdle;
          end else begin
            to_d    = scan_q;
            raddr   = wrap_prev(scan_q);
            state_d = StShift;
          end
        end else if (wrap_next(scan_q) == head_q) begin
          res_valid = 1'b1;
          state_d   = StIdle;
        end else begin
          scan_d = wrap_next(scan_q);
          raddr  = wrap_next(scan_q);
        end
      end
      StShift: begin
        we    = 1'b1;
        waddr = to_q;
        wdata = rdata;
        if (from_idx == tail_q) begin
          tail_d  = wrap_next(tail_q);
          state_d = StIdle;
        end else begin
          to_d  = from_idx;
          raddr = wrap_prev(from_idx);
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    res.queued_count = cnt_d;
    out_d       = res_valid ? res : out_q;
    out_valid_d = res_valid ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      head_q       <= '0;
      tail_q       <= '0;
      cnt_q        <= '0;
      serial_q     <= '0;
      own_window_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      cnt_q       <= cnt_d;
      serial_q    <= serial_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        own_window_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    scan_q <= scan_d;
    to_q   <= to_d;
    op_q   <= op_d;
    type_q <= type_d;
    win_q  <= win_d;
    out_q  <= out_d;
  end

endmodule
